// ===== rtl/core/trc_pkg.sv =====
// Package for the thermostat relay controller: widths, codes, register map,
// reset values and the fixed debounce and default setpoint constants.
// No dependencies.
`default_nettype none

package trc_pkg;

	localparam int TEMP_W = 12;
	localparam int STEP_W = 9;
	localparam int MS_W = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [MS_W-1:0] DEBOUNCE_MS = 16'd50;
	localparam logic signed [TEMP_W-1:0] SETPOINT_POWER_ON = 12'sd320;

	typedef enum logic [1:0] {
		STATUS_UNKNOWN   = 2'd0,
		STATUS_OK        = 2'd1,
		STATUS_NO_SENSOR = 2'd2,
		STATUS_READ_LOST = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_START = 2'd1,
		REQ_READ  = 2'd2
	} request_t;

	typedef enum logic [2:0] {
		REG_SETPOINT_MIN   = 3'd0,
		REG_SETPOINT_MAX   = 3'd1,
		REG_SETPOINT_STEP  = 3'd2,
		REG_HYSTERESIS     = 3'd3,
		REG_MAX_SAFE_TEMP  = 3'd4,
		REG_CUTOFF_RESET   = 3'd5,
		REG_READ_INTERVAL  = 3'd6,
		REG_CONVERSION     = 3'd7
	} reg_index_t;

	localparam logic [TEMP_W-1:0] RST_SETPOINT_MIN = 12'd80;
	localparam logic [TEMP_W-1:0] RST_SETPOINT_MAX = 12'd480;
	localparam logic [STEP_W-1:0] RST_SETPOINT_STEP = 9'd8;
	localparam logic [STEP_W-1:0] RST_HYSTERESIS = 9'd8;
	localparam logic [TEMP_W-1:0] RST_MAX_SAFE_TEMP = 12'd1120;
	localparam logic [TEMP_W-1:0] RST_CUTOFF_RESET = 12'd960;
	localparam logic [MS_W-1:0] RST_READ_INTERVAL = 16'd1000;
	localparam logic [MS_W-1:0] RST_CONVERSION = 16'd750;

endpackage

`default_nettype wire

// ===== rtl/core/trc_if.sv =====
// Valid/ready channel interfaces for the thermostat relay controller: the
// tick channel into the block and the result channel out of it. Uses trc_pkg.
`default_nettype none

interface trc_tick_if;
	logic valid;
	logic ready;
	logic btn_up_level;
	logic btn_down_level;
	logic start_ok;
	logic read_ok;
	logic signed [trc_pkg::TEMP_W-1:0] temperature;

	modport source (output valid, btn_up_level, btn_down_level, start_ok, read_ok,
		temperature, input ready);
	modport sink (input valid, btn_up_level, btn_down_level, start_ok, read_ok,
		temperature, output ready);
	modport monitor (input valid, ready, btn_up_level, btn_down_level, start_ok,
		read_ok, temperature);
endinterface

interface trc_result_if;
	logic valid;
	logic ready;
	logic relay_on;
	logic cutoff_active;
	logic [1:0] sensor_status;
	logic signed [trc_pkg::TEMP_W-1:0] setpoint;
	logic signed [trc_pkg::TEMP_W-1:0] last_temp;
	logic [1:0] sensor_request;

	modport source (output valid, relay_on, cutoff_active, sensor_status, setpoint,
		last_temp, sensor_request, input ready);
	modport sink (input valid, relay_on, cutoff_active, sensor_status, setpoint,
		last_temp, sensor_request, output ready);
	modport monitor (input valid, ready, relay_on, cutoff_active, sensor_status,
		setpoint, last_temp, sensor_request);
endinterface

`default_nettype wire

// ===== rtl/core/thermostat_relay_controller.sv =====
// Top level of the thermostat relay controller: APB register file, tick input
// register, sensor schedule, cutoff, hysteresis and button logic, result register.
// Depends on trc_pkg and the channel interfaces in trc_if.sv.
`default_nettype none

// Each tick request is taken into an input register, processed against the
// controller state and placed in the result register, so one request is
// accepted per clock unless the result channel stalls. Ready drops only while
// both the input register and the result register are full and the result is
// not being taken. Registers sit at byte address 4*i and should be written
// only while no request is in flight.
module thermostat_relay_controller (
	input  wire logic clk,
	input  wire logic arst_n,
	trc_tick_if.sink tick,
	trc_result_if.source result,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [trc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [trc_pkg::DATA_W-1:0] pwdata,
	output logic [trc_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int TW = trc_pkg::TEMP_W;
	localparam int SW = trc_pkg::STEP_W;
	localparam int MW = trc_pkg::MS_W;

	logic [TW-1:0] sp_min_q, sp_max_q, max_safe_q, cutoff_reset_q;
	logic [SW-1:0] sp_step_q, hyst_q;
	logic [MW-1:0] interval_q, conversion_q;
	trc_pkg::reg_index_t reg_idx;
	logic cfg_write;

	logic v_s1;
	logic btn_up_s1, btn_down_s1, start_ok_s1, read_ok_s1;
	logic signed [TW-1:0] temp_s1;

	logic [MW-1:0] req_elapsed_q, btn_elapsed_q;
	logic pending_q, up_armed_q, down_armed_q, relay_q, cutoff_q;
	trc_pkg::status_t status_q;
	logic signed [TW-1:0] setpoint_q, last_temp_q;

	logic out_v_q;

	logic advance, fire;
	logic [MW-1:0] req_inc, btn_inc, req_elapsed_d, btn_elapsed_d;
	logic pending_d, up_armed_d, down_armed_d, relay_d, cutoff_d, cut_next;
	trc_pkg::status_t status_d;
	trc_pkg::request_t request_d;
	logic signed [TW-1:0] setpoint_d, last_temp_d;
	logic signed [TW+1:0] heat_on_below, temp_ext;
	logic signed [TW:0] sp_sum, sp_clamp_max, sp_lim_max, sp_lim_min;
	logic step_up, step_down;

	assign pready = 1'b1;
	assign reg_idx = trc_pkg::reg_index_t'(paddr[trc_pkg::ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_min_q <= trc_pkg::RST_SETPOINT_MIN;
			sp_max_q <= trc_pkg::RST_SETPOINT_MAX;
			sp_step_q <= trc_pkg::RST_SETPOINT_STEP;
			hyst_q <= trc_pkg::RST_HYSTERESIS;
			max_safe_q <= trc_pkg::RST_MAX_SAFE_TEMP;
			cutoff_reset_q <= trc_pkg::RST_CUTOFF_RESET;
			interval_q <= trc_pkg::RST_READ_INTERVAL;
			conversion_q <= trc_pkg::RST_CONVERSION;
		end else if (cfg_write) begin
			unique case (reg_idx)
				trc_pkg::REG_SETPOINT_MIN: sp_min_q <= pwdata[TW-1:0];
				trc_pkg::REG_SETPOINT_MAX: sp_max_q <= pwdata[TW-1:0];
				trc_pkg::REG_SETPOINT_STEP: sp_step_q <= pwdata[SW-1:0];
				trc_pkg::REG_HYSTERESIS: hyst_q <= pwdata[SW-1:0];
				trc_pkg::REG_MAX_SAFE_TEMP: max_safe_q <= pwdata[TW-1:0];
				trc_pkg::REG_CUTOFF_RESET: cutoff_reset_q <= pwdata[TW-1:0];
				trc_pkg::REG_READ_INTERVAL: interval_q <= pwdata[MW-1:0];
				trc_pkg::REG_CONVERSION: conversion_q <= pwdata[MW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			trc_pkg::REG_SETPOINT_MIN: prdata[TW-1:0] = sp_min_q;
			trc_pkg::REG_SETPOINT_MAX: prdata[TW-1:0] = sp_max_q;
			trc_pkg::REG_SETPOINT_STEP: prdata[SW-1:0] = sp_step_q;
			trc_pkg::REG_HYSTERESIS: prdata[SW-1:0] = hyst_q;
			trc_pkg::REG_MAX_SAFE_TEMP: prdata[TW-1:0] = max_safe_q;
			trc_pkg::REG_CUTOFF_RESET: prdata[TW-1:0] = cutoff_reset_q;
			trc_pkg::REG_READ_INTERVAL: prdata[MW-1:0] = interval_q;
			trc_pkg::REG_CONVERSION: prdata[MW-1:0] = conversion_q;
			default: prdata = '0;
		endcase
	end

	// The input register moves on whenever the result register is free or is
	// being emptied in this cycle.
	assign advance = !out_v_q || result.ready;
	assign fire = v_s1 && advance;
	assign tick.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			btn_up_s1 <= tick.btn_up_level;
			btn_down_s1 <= tick.btn_down_level;
			start_ok_s1 <= tick.start_ok;
			read_ok_s1 <= tick.read_ok;
			temp_s1 <= tick.temperature;
		end
	end

	assign req_inc = (req_elapsed_q == {MW{1'b1}}) ? req_elapsed_q : req_elapsed_q + 1'b1;
	assign btn_inc = (btn_elapsed_q == {MW{1'b1}}) ? btn_elapsed_q : btn_elapsed_q + 1'b1;
	assign temp_ext = {{2{temp_s1[TW-1]}}, temp_s1};
	assign heat_on_below = {{2{setpoint_q[TW-1]}}, setpoint_q} - {5'd0, hyst_q};
	assign cut_next = ($signed(temp_s1) >= $signed(max_safe_q)) ? 1'b1 :
		(cutoff_q && ($signed(temp_s1) < $signed(cutoff_reset_q))) ? 1'b0 : cutoff_q;

	always_comb begin
		pending_d = pending_q;
		req_elapsed_d = req_inc;
		status_d = status_q;
		relay_d = relay_q;
		cutoff_d = cutoff_q;
		last_temp_d = last_temp_q;
		request_d = trc_pkg::REQ_NONE;
		if (!pending_q) begin
			if (req_inc >= interval_q) begin
				req_elapsed_d = '0;
				request_d = trc_pkg::REQ_START;
				if (start_ok_s1) begin
					pending_d = 1'b1;
				end else begin
					status_d = trc_pkg::STATUS_NO_SENSOR;
					relay_d = 1'b0;
				end
			end
		end else if (req_inc >= conversion_q) begin
			pending_d = 1'b0;
			request_d = trc_pkg::REQ_READ;
			if (read_ok_s1) begin
				status_d = trc_pkg::STATUS_OK;
				last_temp_d = temp_s1;
				cutoff_d = cut_next;
				if ($signed(temp_s1) >= $signed(max_safe_q)) begin
					relay_d = 1'b0;
				end
				if (!cut_next) begin
					if (temp_ext < heat_on_below) begin
						relay_d = 1'b1;
					end else if (temp_s1 >= setpoint_q) begin
						relay_d = 1'b0;
					end
				end
			end else begin
				status_d = trc_pkg::STATUS_READ_LOST;
				relay_d = 1'b0;
			end
		end
	end

	// Up has priority; a release re-arms a button once the debounce time is up.
	assign step_up = (btn_inc >= trc_pkg::DEBOUNCE_MS) && !btn_up_s1 && up_armed_q;
	assign step_down = (btn_inc >= trc_pkg::DEBOUNCE_MS) && !step_up && !btn_down_s1
		&& down_armed_q;
	assign sp_lim_max = {sp_max_q[TW-1], sp_max_q};
	assign sp_lim_min = {sp_min_q[TW-1], sp_min_q};
	assign sp_sum = step_up ? ({setpoint_q[TW-1], setpoint_q} + {4'd0, sp_step_q})
		: ({setpoint_q[TW-1], setpoint_q} - {4'd0, sp_step_q});
	assign sp_clamp_max = (sp_sum > sp_lim_max) ? sp_lim_max : sp_sum;

	always_comb begin
		up_armed_d = up_armed_q;
		down_armed_d = down_armed_q;
		btn_elapsed_d = btn_inc;
		setpoint_d = setpoint_q;
		if (btn_inc >= trc_pkg::DEBOUNCE_MS) begin
			if (btn_up_s1 && !up_armed_q) begin
				up_armed_d = 1'b1;
				btn_elapsed_d = '0;
			end
			if (btn_down_s1 && !down_armed_q) begin
				down_armed_d = 1'b1;
				btn_elapsed_d = '0;
			end
			if (step_up) begin
				up_armed_d = 1'b0;
				btn_elapsed_d = '0;
			end
			if (step_down) begin
				down_armed_d = 1'b0;
				btn_elapsed_d = '0;
			end
			if (step_up || step_down) begin
				setpoint_d = (sp_clamp_max < sp_lim_min) ? sp_min_q : sp_clamp_max[TW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_elapsed_q <= '0;
			btn_elapsed_q <= '0;
			pending_q <= 1'b0;
			up_armed_q <= 1'b1;
			down_armed_q <= 1'b1;
			relay_q <= 1'b0;
			cutoff_q <= 1'b0;
			status_q <= trc_pkg::STATUS_UNKNOWN;
			setpoint_q <= trc_pkg::SETPOINT_POWER_ON;
			last_temp_q <= '0;
		end else if (fire) begin
			req_elapsed_q <= req_elapsed_d;
			btn_elapsed_q <= btn_elapsed_d;
			pending_q <= pending_d;
			up_armed_q <= up_armed_d;
			down_armed_q <= down_armed_d;
			relay_q <= relay_d;
			cutoff_q <= cutoff_d;
			status_q <= status_d;
			setpoint_q <= setpoint_d;
			last_temp_q <= last_temp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result.relay_on <= relay_d;
			result.cutoff_active <= cutoff_d;
			result.sensor_status <= status_d;
			result.setpoint <= setpoint_d;
			result.last_temp <= last_temp_d;
			result.sensor_request <= request_d;
		end
	end

	assign result.valid = out_v_q;

endmodule

`default_nettype wire

// ===== rtl/core/trc_checker.sv =====
// Port-level checker for the thermostat relay controller, with its bind.
// Depends on trc_pkg.
`default_nettype none

module trc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic tick_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic relay_on,
	input wire logic cutoff_active,
	input wire logic [1:0] sensor_status,
	input wire logic [trc_pkg::TEMP_W-1:0] setpoint,
	input wire logic [trc_pkg::TEMP_W-1:0] last_temp,
	input wire logic [1:0] sensor_request
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(relay_on)
		&& $stable(cutoff_active) && $stable(sensor_status)
		&& $stable(setpoint) && $stable(last_temp)
		&& $stable(sensor_request))
		else $error("result request changed while stalled");

	a_cutoff_relay_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(relay_on && cutoff_active))
		else $error("relay on while safety cutoff is latched");

	a_relay_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && relay_on |->
		sensor_status == trc_pkg::STATUS_OK)
		else $error("relay on without a good sensor status");

	a_request_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (sensor_request == trc_pkg::REQ_NONE
		|| sensor_request == trc_pkg::REQ_START || sensor_request == trc_pkg::REQ_READ))
		else $error("undefined sensor request code");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> tick_ready)
		else $error("tick request refused while the result register is empty");

endmodule

bind thermostat_relay_controller trc_checker u_trc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.tick_ready(tick.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.relay_on(result.relay_on),
	.cutoff_active(result.cutoff_active),
	.sensor_status(result.sensor_status),
	.setpoint(result.setpoint),
	.last_temp(result.last_temp),
	.sensor_request(result.sensor_request)
);

`default_nettype wire

// ===== verif/thermostat_relay_controller_test.sv =====
// Self-checking bench for thermostat_relay_controller: drives millisecond ticks and APB register
// writes, predicts every result with a cycle-free model of the controller and compares them.
// Depends on trc_pkg, the channel interfaces in trc_if.sv and the controller itself.
`default_nettype none

module thermostat_relay_controller_test;

	typedef struct packed {
		logic up_n;
		logic down_n;
		logic start_ok;
		logic read_ok;
		logic signed [trc_pkg::TEMP_W-1:0] temperature;
	} tick_t;

	typedef struct packed {
		logic relay_on;
		logic cutoff_active;
		trc_pkg::status_t status;
		logic signed [trc_pkg::TEMP_W-1:0] setpoint;
		logic signed [trc_pkg::TEMP_W-1:0] last_temp;
		trc_pkg::request_t request;
	} thermo_out_t;

	class relay_scoreboard;
		logic signed [trc_pkg::TEMP_W-1:0] sp_min, sp_max, safe_temp, clear_temp;
		logic [trc_pkg::STEP_W-1:0] sp_step, hyst;
		logic [trc_pkg::MS_W-1:0] interval_ms, conv_ms;
		logic [trc_pkg::MS_W-1:0] req_elapsed, btn_elapsed;
		bit conv_pending, up_armed, down_armed, relay, cutoff;
		trc_pkg::status_t status;
		logic signed [trc_pkg::TEMP_W:0] setpoint_q, last_temp_q;
		thermo_out_t expected_q[$];
		int errors, ticks, starts, reads, steps, trips;

		function void reset_state();
			sp_min = trc_pkg::RST_SETPOINT_MIN;
			sp_max = trc_pkg::RST_SETPOINT_MAX;
			sp_step = trc_pkg::RST_SETPOINT_STEP;
			hyst = trc_pkg::RST_HYSTERESIS;
			safe_temp = trc_pkg::RST_MAX_SAFE_TEMP;
			clear_temp = trc_pkg::RST_CUTOFF_RESET;
			interval_ms = trc_pkg::RST_READ_INTERVAL;
			conv_ms = trc_pkg::RST_CONVERSION;
			req_elapsed = '0;
			btn_elapsed = '0;
			conv_pending = 1'b0;
			up_armed = 1'b1;
			down_armed = 1'b1;
			relay = 1'b0;
			cutoff = 1'b0;
			status = trc_pkg::STATUS_UNKNOWN;
			setpoint_q = trc_pkg::SETPOINT_POWER_ON;
			last_temp_q = '0;
		endfunction

		function void set_register(trc_pkg::reg_index_t idx, logic [trc_pkg::DATA_W-1:0] v);
			case (idx)
				trc_pkg::REG_SETPOINT_MIN: sp_min = v[trc_pkg::TEMP_W-1:0];
				trc_pkg::REG_SETPOINT_MAX: sp_max = v[trc_pkg::TEMP_W-1:0];
				trc_pkg::REG_SETPOINT_STEP: sp_step = v[trc_pkg::STEP_W-1:0];
				trc_pkg::REG_HYSTERESIS: hyst = v[trc_pkg::STEP_W-1:0];
				trc_pkg::REG_MAX_SAFE_TEMP: safe_temp = v[trc_pkg::TEMP_W-1:0];
				trc_pkg::REG_CUTOFF_RESET: clear_temp = v[trc_pkg::TEMP_W-1:0];
				trc_pkg::REG_READ_INTERVAL: interval_ms = v[trc_pkg::MS_W-1:0];
				trc_pkg::REG_CONVERSION: conv_ms = v[trc_pkg::MS_W-1:0];
				default: ;
			endcase
		endfunction

		function void move_setpoint(int delta);
			int s;
			s = int'(setpoint_q) + delta;
			if (s > int'(sp_max)) s = int'(sp_max);
			if (s < int'(sp_min)) s = int'(sp_min);
			setpoint_q = s[trc_pkg::TEMP_W:0];
			steps++;
		endfunction

		function void take_tick(tick_t t);
			trc_pkg::request_t req;
			int tv;
			thermo_out_t o;
			req = trc_pkg::REQ_NONE;
			tv = $signed(t.temperature);
			ticks++;
			if (req_elapsed != '1) req_elapsed++;
			if (btn_elapsed != '1) btn_elapsed++;
			if (!conv_pending) begin
				if (req_elapsed >= interval_ms) begin
					req_elapsed = '0;
					req = trc_pkg::REQ_START;
					starts++;
					if (t.start_ok) begin
						conv_pending = 1'b1;
					end else begin
						status = trc_pkg::STATUS_NO_SENSOR;
						relay = 1'b0;
					end
				end
			end else if (req_elapsed >= conv_ms) begin
				conv_pending = 1'b0;
				req = trc_pkg::REQ_READ;
				if (t.read_ok) begin
					reads++;
					status = trc_pkg::STATUS_OK;
					last_temp_q = tv[trc_pkg::TEMP_W:0];
					if (tv >= int'(safe_temp)) begin
						if (!cutoff) trips++;
						cutoff = 1'b1;
						relay = 1'b0;
					end else if (cutoff && tv < int'(clear_temp)) begin
						cutoff = 1'b0;
					end
					if (!cutoff) begin
						if (tv < int'(setpoint_q) - int'(hyst)) relay = 1'b1;
						else if (tv >= int'(setpoint_q)) relay = 1'b0;
					end
				end else begin
					status = trc_pkg::STATUS_READ_LOST;
					relay = 1'b0;
				end
			end
			if (btn_elapsed >= trc_pkg::DEBOUNCE_MS) begin
				if (t.up_n && !up_armed) begin
					up_armed = 1'b1;
					btn_elapsed = '0;
				end
				if (t.down_n && !down_armed) begin
					down_armed = 1'b1;
					btn_elapsed = '0;
				end
				if (!t.up_n && up_armed) begin
					up_armed = 1'b0;
					btn_elapsed = '0;
					move_setpoint(int'(sp_step));
				end else if (!t.down_n && down_armed) begin
					down_armed = 1'b0;
					btn_elapsed = '0;
					move_setpoint(-int'(sp_step));
				end
			end
			o.relay_on = relay;
			o.cutoff_active = cutoff;
			o.status = status;
			o.setpoint = setpoint_q[trc_pkg::TEMP_W-1:0];
			o.last_temp = last_temp_q[trc_pkg::TEMP_W-1:0];
			o.request = req;
			expected_q.push_back(o);
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
			end
		endfunction

		function void check_output(thermo_out_t got);
			thermo_out_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, expected none, got %h",
					$time, got);
			end else begin
				want = expected_q.pop_front();
				compare_field("relay_on", want.relay_on, got.relay_on);
				compare_field("cutoff_active", want.cutoff_active, got.cutoff_active);
				compare_field("sensor_status", want.status, got.status);
				compare_field("setpoint", want.setpoint, got.setpoint);
				compare_field("last_temp", want.last_temp, got.last_temp);
				compare_field("sensor_request", want.request, got.request);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [trc_pkg::ADDR_W-1:0] paddr;
	logic [trc_pkg::DATA_W-1:0] pwdata;
	logic [trc_pkg::DATA_W-1:0] prdata;
	logic pready;

	trc_tick_if tick_ch();
	trc_result_if result_ch();

	thermostat_relay_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	relay_scoreboard sb = new();
	bit calm;
	int ready_hold;
	int settings_done;
	bit up_level, dn_level;
	int up_left, dn_left;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#4000000;
		$display("[thermostat_relay_controller] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			result_ch.ready <= 1'b0;
			ready_hold = $urandom_range(0, 11);
		end else begin
			result_ch.ready <= 1'b1;
			ready_hold = $urandom_range(0, 30);
		end
	end

	always @(posedge clk) begin
		thermo_out_t got;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.relay_on = result_ch.relay_on;
			got.cutoff_active = result_ch.cutoff_active;
			got.status = trc_pkg::status_t'(result_ch.sensor_status);
			got.setpoint = result_ch.setpoint;
			got.last_temp = result_ch.last_temp;
			got.request = trc_pkg::request_t'(result_ch.sensor_request);
			sb.check_output(got);
		end
	end

	task automatic write_reg(input trc_pkg::reg_index_t idx,
			input logic [trc_pkg::DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_register(idx, v);
	endtask

	task automatic apply_settings(input int mn, input int mx, input int stp, input int hy,
			input int safe, input int clr, input int ivl, input int cnv);
		write_reg(trc_pkg::REG_SETPOINT_MIN, mn & 'hFFF);
		write_reg(trc_pkg::REG_SETPOINT_MAX, mx & 'hFFF);
		write_reg(trc_pkg::REG_SETPOINT_STEP, stp & 'h1FF);
		write_reg(trc_pkg::REG_HYSTERESIS, hy & 'h1FF);
		write_reg(trc_pkg::REG_MAX_SAFE_TEMP, safe & 'hFFF);
		write_reg(trc_pkg::REG_CUTOFF_RESET, clr & 'hFFF);
		write_reg(trc_pkg::REG_READ_INTERVAL, ivl & 'hFFFF);
		write_reg(trc_pkg::REG_CONVERSION, cnv & 'hFFFF);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_done++;
	endtask

	task automatic random_settings(input int ivl, input int cnv);
		int mn, mx, safe;
		mn = $urandom_range(0, 1880);
		mn -= 880;
		mx = mn + $urandom_range(0, 600);
		if (mx > 2000) mx = 2000;
		safe = $urandom_range(200, 2000);
		apply_settings(mn, mx, $urandom_range(1, 64), $urandom_range(0, 40), safe,
			safe - $urandom_range(0, 200), ivl, cnv);
	endtask

	task automatic send_tick(input tick_t t);
		if (!calm && $urandom_range(0, 5) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.btn_up_level <= t.up_n;
		tick_ch.btn_down_level <= t.down_n;
		tick_ch.start_ok <= t.start_ok;
		tick_ch.read_ok <= t.read_ok;
		tick_ch.temperature <= t.temperature;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		sb.take_tick(t);
	endtask

	// Holds off new ticks until every result is back, then lets the pipeline settle.
	task automatic drain();
		tick_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic tick_t make_tick(bit up_n, bit down_n, bit s_ok, bit r_ok, int tv);
		tick_t t;
		t.up_n = up_n;
		t.down_n = down_n;
		t.start_ok = s_ok;
		t.read_ok = r_ok;
		t.temperature = tv[trc_pkg::TEMP_W-1:0];
		return t;
	endfunction

	// Buttons are held and released for realistic stretches, with occasional single-tick glitches.
	function automatic tick_t random_tick();
		tick_t t;
		int tv, jitter, sp;
		if (up_left == 0) begin
			up_level = !up_level;
			up_left = up_level ? $urandom_range(1, 120) : $urandom_range(1, 90);
		end
		up_left--;
		if (dn_left == 0) begin
			dn_level = !dn_level;
			dn_left = dn_level ? $urandom_range(1, 120) : $urandom_range(1, 90);
		end
		dn_left--;
		t.up_n = up_level ^ ($urandom_range(0, 11) == 0);
		t.down_n = dn_level ^ ($urandom_range(0, 11) == 0);
		t.start_ok = $urandom_range(0, 7) != 0;
		t.read_ok = $urandom_range(0, 7) != 0;
		jitter = $urandom_range(0, 8);
		jitter -= 4;
		sp = sb.setpoint_q;
		case ($urandom_range(0, 9))
			0, 1: tv = sp - int'(sb.hyst) + jitter;
			2, 3: tv = sp + jitter;
			4, 5: tv = int'(sb.safe_temp) + jitter;
			6: tv = int'(sb.clear_temp) + jitter;
			default: begin
				tv = $urandom_range(0, 4095);
				tv -= 2048;
			end
		endcase
		if (tv > 2047) tv = 2047;
		if (tv < -2048) tv = -2048;
		t.temperature = tv[trc_pkg::TEMP_W-1:0];
		return t;
	endfunction

	task automatic random_phase(input int n);
		repeat (n) send_tick(random_tick());
		drain();
	endtask

	initial begin
		tick_t directed_q[$];
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.btn_up_level = 1'b1;
		tick_ch.btn_down_level = 1'b1;
		tick_ch.start_ok = 1'b0;
		tick_ch.read_ok = 1'b0;
		tick_ch.temperature = '0;
		result_ch.ready = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		ready_hold = 0;
		settings_done = 0;
		up_level = 1'b1;
		dn_level = 1'b1;
		up_left = 30;
		dn_left = 45;
		sb.reset_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero interval and conversion time: every tick starts or reads; reads follow good starts.
		write_reg(trc_pkg::REG_READ_INTERVAL, 0);
		write_reg(trc_pkg::REG_CONVERSION, 0);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		directed_q.push_back(make_tick(1, 1, 1, 0, -2048));
		directed_q.push_back(make_tick(0, 0, 0, 1, 2047));
		directed_q.push_back(make_tick(1, 0, 1, 0, 0));
		directed_q.push_back(make_tick(0, 1, 0, 1, 1000));
		directed_q.push_back(make_tick(1, 1, 1, 1, 2047));
		directed_q.push_back(make_tick(1, 1, 0, 1, 959));
		directed_q.push_back(make_tick(0, 0, 0, 1, 100));
		directed_q.push_back(make_tick(1, 1, 1, 1, 0));
		directed_q.push_back(make_tick(1, 1, 1, 0, 2047));
		directed_q.push_back(make_tick(1, 1, 1, 0, -1));
		directed_q.push_back(make_tick(1, 1, 0, 1, 312));
		directed_q.push_back(make_tick(1, 1, 1, 0, 1365));
		directed_q.push_back(make_tick(1, 1, 0, 1, 311));
		directed_q.push_back(make_tick(1, 1, 1, 0, -1366));
		directed_q.push_back(make_tick(1, 1, 0, 1, 320));
		directed_q.push_back(make_tick(1, 1, 1, 0, 0));
		directed_q.push_back(make_tick(1, 1, 0, 1, -2048));
		directed_q.push_back(make_tick(1, 1, 1, 0, 0));
		directed_q.push_back(make_tick(1, 1, 0, 1, 1120));
		directed_q.push_back(make_tick(1, 1, 1, 0, 0));
		directed_q.push_back(make_tick(1, 1, 0, 1, 960));
		foreach (directed_q[i]) send_tick(directed_q[i]);
		drain();

		apply_settings(-880, 2000, 320, 320, 2000, -880, 1, 1);
		random_phase(150);
		// Crossed clamps with a zero step pin the setpoint to the minimum.
		apply_settings(400, 100, 0, 0, 500, 400, 3, 2);
		random_phase(150);
		apply_settings(-2048, 2047, 511, 511, -2048, 2047, 2, 1);
		random_phase(150);
		random_settings(65535, 65535);
		random_phase(80);
		random_settings($urandom_range(1, 12), $urandom_range(1, 10));
		random_phase(155);
		apply_settings(trc_pkg::RST_SETPOINT_MIN, trc_pkg::RST_SETPOINT_MAX,
			trc_pkg::RST_SETPOINT_STEP, trc_pkg::RST_HYSTERESIS,
			trc_pkg::RST_MAX_SAFE_TEMP, trc_pkg::RST_CUTOFF_RESET, 6, 4);
		random_phase(155);
		random_settings($urandom_range(1, 12), $urandom_range(1, 10));
		random_phase(155);
		calm = 1'b1;
		random_settings($urandom_range(1, 12), $urandom_range(1, 10));
		random_phase(155);
		repeat (10) @(posedge clk);

		$display("Ran %0d ticks over %0d register settings: %0d sensor starts, %0d good reads,",
			sb.ticks, settings_done + 1, sb.starts, sb.reads);
		$display("%0d setpoint steps and %0d cutoff trips.", sb.steps, sb.trips);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("[thermostat_relay_controller] OK");
		end else begin
			$display("[thermostat_relay_controller] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
